### src/pid_with_antiwindup_assert.svh
// assertion macros shared by the checker
// no dependencies
`ifndef PID_WITH_ANTIWINDUP_ASSERT_SVH
`define PID_WITH_ANTIWINDUP_ASSERT_SVH

// same-cycle implication
`define PWA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PWA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/pwa_pkg.sv
// types and constants of the pid controller with integral clamp
// no dependencies
package pwa_pkg;

    localparam logic [1:0] REG_KP    = 2'd0;
    localparam logic [1:0] REG_KI    = 2'd1;
    localparam logic [1:0] REG_KD    = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] error_value;
        logic [31:0] time_step;
    } in_word_t;

    typedef struct packed {
        logic [31:0] drive;
        logic        drive_saturated;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_INC,
        ST_ACC,
        ST_DIV_B,
        ST_CLAMP,
        ST_DPREP,
        ST_DIV_D,
        ST_DSAT,
        ST_LOAD_I,
        ST_MUL_I,
        ST_MUL_D,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

### src/pid_with_antiwindup.sv
// pid controller with integral clamp, shift-add multiplier and restoring divider
// depends on pwa_pkg
// a clear word goes straight to the result; a zero time step runs only the
// proportional multiply; a control step runs four multiplies and up to two
// divides on one shared multiplier and one divider
// throughput: one word at a time; the next word is taken once the result is registered
// reset: gains, limit, integral and previous error cleared, no result pending
module pid_with_antiwindup (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pwa_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output pwa_pkg::out_word_t out_word,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam logic [5:0] MUL_LAST = 6'd32;
    localparam logic [5:0] DIV_LAST = 6'd56;
    localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;

    pwa_pkg::state_t state_reg, state_next;

    logic [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0] limit_reg;
    logic [47:0] integ_reg;
    logic [31:0] last_reg;
    logic        have_reg;

    logic [31:0] e_reg, dt_reg;
    logic [80:0] mcand_reg, prod_reg, sum_reg;
    logic [32:0] mplier_reg;
    logic [5:0]  cnt_reg;
    logic [56:0] num_reg, quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic        neg_reg;
    logic [31:0] d_reg;
    logic [48:0] inc_reg;

    pwa_pkg::out_word_t res_reg, out_reg;
    logic               out_valid_reg;

    logic [80:0] mul_prod_next;
    logic [80:0] addend;
    logic [32:0] rem_shift;
    logic        div_ge;
    logic [32:0] rem_next;
    logic [56:0] quo_next;
    logic        mul_end, div_end, out_free;
    logic [49:0] acc_sum;
    logic [32:0] diff, diff_mag;
    logic [31:0] ki_mag;
    logic [47:0] bound;
    logic [64:0] fin_s;
    logic        fin_ok;

    always_comb
    begin
        addend = mplier_reg[0] ? mcand_reg : 81'd0;
        if (cnt_reg == MUL_LAST)
            mul_prod_next = prod_reg - addend;
        else
            mul_prod_next = prod_reg + addend;
        rem_shift = {rem_reg, num_reg[56]};
        div_ge    = rem_shift >= {1'b0, div_reg};
        rem_next  = div_ge ? rem_shift - {1'b0, div_reg} : rem_shift;
        quo_next  = {quo_reg[55:0], div_ge};
        mul_end   = cnt_reg == MUL_LAST;
        div_end   = cnt_reg == DIV_LAST;
        out_free  = !out_valid_reg || !out_stall;
        acc_sum   = {{2{integ_reg[47]}}, integ_reg} + {inc_reg[48], inc_reg};
        diff      = {e_reg[31], e_reg} - {last_reg[31], last_reg};
        diff_mag  = diff[32] ? 33'd0 - diff : diff;
        ki_mag    = ki_reg[31] ? 32'd0 - ki_reg : ki_reg;
        bound     = (|quo_reg[56:47]) ? MAX48 : quo_reg[47:0];
        fin_s     = sum_reg[80:16];
        fin_ok    = (&fin_s[64:31]) || !(|fin_s[64:31]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwa_pkg::ST_IDLE:
                if (in_valid)
                    state_next = (in_word.kind == pwa_pkg::KIND_CLEAR) ?
                                 pwa_pkg::ST_DONE : pwa_pkg::ST_MUL_P;
            pwa_pkg::ST_MUL_P:
                if (mul_end)
                    state_next = (dt_reg == 32'd0) ? pwa_pkg::ST_FIN : pwa_pkg::ST_MUL_INC;
            pwa_pkg::ST_MUL_INC:
                if (mul_end)
                    state_next = pwa_pkg::ST_ACC;
            pwa_pkg::ST_ACC:
                state_next = (ki_reg != 32'd0) ? pwa_pkg::ST_DIV_B : pwa_pkg::ST_DPREP;
            pwa_pkg::ST_DIV_B:
                if (div_end)
                    state_next = pwa_pkg::ST_CLAMP;
            pwa_pkg::ST_CLAMP:
                state_next = pwa_pkg::ST_DPREP;
            pwa_pkg::ST_DPREP:
                state_next = have_reg ? pwa_pkg::ST_DIV_D : pwa_pkg::ST_LOAD_I;
            pwa_pkg::ST_DIV_D:
                if (div_end)
                    state_next = pwa_pkg::ST_DSAT;
            pwa_pkg::ST_DSAT:
                state_next = pwa_pkg::ST_LOAD_I;
            pwa_pkg::ST_LOAD_I:
                state_next = pwa_pkg::ST_MUL_I;
            pwa_pkg::ST_MUL_I:
                if (mul_end)
                    state_next = pwa_pkg::ST_MUL_D;
            pwa_pkg::ST_MUL_D:
                if (mul_end)
                    state_next = pwa_pkg::ST_FIN;
            pwa_pkg::ST_FIN:
                state_next = pwa_pkg::ST_DONE;
            pwa_pkg::ST_DONE:
                if (out_free)
                    state_next = pwa_pkg::ST_IDLE;
            default:
                state_next = pwa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = state_reg != pwa_pkg::ST_IDLE;
        out_valid = out_valid_reg;
        out_word  = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            limit_reg     <= '0;
            integ_reg     <= '0;
            last_reg      <= '0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pwa_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pwa_pkg::REG_KP:    kp_reg <= cfg_data;
                    pwa_pkg::REG_KI:
                    begin
                        if (cfg_data != ki_reg)
                            integ_reg <= '0;
                        ki_reg <= cfg_data;
                    end
                    pwa_pkg::REG_KD:    kd_reg <= cfg_data;
                    pwa_pkg::REG_LIMIT: limit_reg <= cfg_data[30:0];
                    default:            kp_reg <= kp_reg;
                endcase
            end
            unique case (state_reg)
                pwa_pkg::ST_IDLE:
                    if (in_valid)
                    begin
                        e_reg      <= in_word.error_value;
                        dt_reg     <= in_word.time_step;
                        mcand_reg  <= {{49{in_word.error_value[31]}}, in_word.error_value};
                        mplier_reg <= {kp_reg[31], kp_reg};
                        prod_reg   <= '0;
                        cnt_reg    <= '0;
                        if (in_word.kind == pwa_pkg::KIND_CLEAR)
                        begin
                            integ_reg <= '0;
                            last_reg  <= '0;
                            have_reg  <= 1'b0;
                            res_reg   <= '0;
                        end
                    end
                pwa_pkg::ST_MUL_P, pwa_pkg::ST_MUL_INC, pwa_pkg::ST_MUL_I, pwa_pkg::ST_MUL_D:
                begin
                    if (!mul_end)
                    begin
                        prod_reg   <= mul_prod_next;
                        mcand_reg  <= {mcand_reg[79:0], 1'b0};
                        mplier_reg <= {mplier_reg[32], mplier_reg[32:1]};
                        cnt_reg    <= cnt_reg + 6'd1;
                    end
                    else
                    begin
                        prod_reg <= '0;
                        cnt_reg  <= '0;
                        if (state_reg == pwa_pkg::ST_MUL_P)
                        begin
                            sum_reg    <= mul_prod_next;
                            mcand_reg  <= {{49{e_reg[31]}}, e_reg};
                            mplier_reg <= {1'b0, dt_reg};
                        end
                        else if (state_reg == pwa_pkg::ST_MUL_INC)
                            inc_reg <= mul_prod_next[64:16];
                        else if (state_reg == pwa_pkg::ST_MUL_I)
                        begin
                            sum_reg    <= sum_reg + {{8{mul_prod_next[80]}}, mul_prod_next[80:8]};
                            mcand_reg  <= {{49{d_reg[31]}}, d_reg};
                            mplier_reg <= {kd_reg[31], kd_reg};
                        end
                        else
                            sum_reg <= sum_reg + mul_prod_next;
                    end
                end
                pwa_pkg::ST_ACC:
                begin
                    if (ki_reg == 32'd0)
                        integ_reg <= '0;
                    else if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111)
                        integ_reg <= acc_sum[47:0];
                    else
                        integ_reg <= acc_sum[49] ? ~MAX48 : MAX48;
                    num_reg <= {2'b00, limit_reg, 24'd0};
                    div_reg <= ki_mag;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                end
                pwa_pkg::ST_DIV_B, pwa_pkg::ST_DIV_D:
                begin
                    rem_reg <= rem_next[31:0];
                    quo_reg <= quo_next;
                    num_reg <= {num_reg[55:0], 1'b0};
                    cnt_reg <= div_end ? 6'd0 : cnt_reg + 6'd1;
                end
                pwa_pkg::ST_CLAMP:
                    if ($signed(integ_reg) > $signed(bound))
                        integ_reg <= bound;
                    else if ($signed(integ_reg) < -$signed(bound))
                        integ_reg <= 48'd0 - bound;
                pwa_pkg::ST_DPREP:
                begin
                    d_reg    <= '0;
                    neg_reg  <= diff[32];
                    num_reg  <= {diff_mag, 24'd0};
                    div_reg  <= dt_reg;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= '0;
                    last_reg <= e_reg;
                    have_reg <= 1'b1;
                end
                pwa_pkg::ST_DSAT:
                    if (!neg_reg)
                        d_reg <= (|quo_reg[56:31]) ? 32'h7FFF_FFFF : quo_reg[31:0];
                    else if ((|quo_reg[56:32]) || (quo_reg[31] && (|quo_reg[30:0])))
                        d_reg <= 32'h8000_0000;
                    else
                        d_reg <= 32'd0 - quo_reg[31:0];
                pwa_pkg::ST_LOAD_I:
                begin
                    mcand_reg  <= {{33{integ_reg[47]}}, integ_reg};
                    mplier_reg <= {ki_reg[31], ki_reg};
                    prod_reg   <= '0;
                    cnt_reg    <= '0;
                end
                pwa_pkg::ST_FIN:
                begin
                    res_reg.drive_saturated <= !fin_ok;
                    if (fin_ok)
                        res_reg.drive <= fin_s[31:0];
                    else
                        res_reg.drive <= fin_s[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                pwa_pkg::ST_DONE:
                    if (out_free)
                        out_reg <= res_reg;
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### src/pwa_checker.sv
// port-level checker for the pid controller, with its bind
// depends on pwa_pkg and pid_with_antiwindup_assert.svh
`include "pid_with_antiwindup_assert.svh"

module pwa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input pwa_pkg::in_word_t  in_word,
    input logic               out_valid,
    input logic               out_stall,
    input pwa_pkg::out_word_t out_word,
    input logic               cfg_we,
    input logic [1:0]         cfg_index,
    input logic [31:0]        cfg_data
);

    `PWA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
    `PWA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `PWA_ASSERT_NOW(a_sat_value, out_valid && out_word.drive_saturated, out_word.drive == 32'h7FFF_FFFF || out_word.drive == 32'h8000_0000)

endmodule

bind pid_with_antiwindup pwa_checker u_pwa_checker (.*);
